// ===== rtl/core/adl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Adaline delta-rule neuron.
// No dependencies; used by the top level adaline_delta_rule_neuron.
package adl_pkg;

  // Default geometry of the retina and the fixed-point format.
  localparam int NUM_INPUTS_DEF = 48;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int MAX_INPUTS     = 64;

  // Field widths.
  localparam int PIX_W      = 48;
  localparam int WIDX_W     = 6;
  localparam int WORD_W     = 32;
  localparam int RATE_W     = 16;
  localparam int TOL_W      = 31;
  localparam int CMD_W      = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;

  // Register reset values.
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(655);
  localparam logic [TOL_W-1:0]  TOL1_RESET = TOL_W'(1677722);
  localparam logic [TOL_W-1:0]  TOL0_RESET = TOL_W'(3355443);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TRAIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_RATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOL1 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOL0 = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [PIX_W-1:0]         pixels;
    logic                     target;
    logic [WIDX_W-1:0]        weight_index;
    logic signed [WORD_W-1:0] weight_value;
  } adl_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] potential;
    logic signed [WORD_W-1:0] error;
    logic                     out_of_tolerance;
  } adl_out_t;

endpackage

// ===== rtl/core/adaline_delta_rule_neuron.sv =====
`timescale 1ns / 1ps
// Adaline neuron trained by the LMS delta rule, weights held in one memory.
// Depends on adl_pkg for the item types, command codes and register defaults.
//
// Usage: items enter on in_valid/in_ready carrying a command. A train item
// sums the weights of the lit pixels, reports potential, error and the
// tolerance flag, then adds the rounded rate-times-error step to every lit
// weight with saturation. An evaluate item does the same without the update.
// A write item loads one weight and answers with all fields zero, as does
// the unused command code. Every item gives exactly one result item on
// out_valid/out_ready. Configuration must be written through cfg_we/cfg_addr/
// cfg_data while the block is idle; the block does not enforce this. No read-back.
//
// Timing: the weight memory has one read port and one write port and is
// swept one entry a cycle. One item is processed at a time; the next is
// accepted as soon as the previous result has been loaded into the output
// register, even if the receiver has not yet taken it. If the receiver
// stalls with a result still waiting, the finished item holds in its last
// stage. Reset (synchronous, active high) clears the per-weight valid bits,
// so all weights read as zero, restores the register defaults and empties
// the output.
module adaline_delta_rule_neuron #(
  parameter int NUM_INPUTS = adl_pkg::NUM_INPUTS_DEF,
  parameter int FRAC_BITS  = adl_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  adl_pkg::adl_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output adl_pkg::adl_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [adl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [adl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import adl_pkg::*;

  // Index and counter widths; the counter can hold NUM_INPUTS itself.
  localparam int IDX_W  = $clog2(NUM_INPUTS);
  localparam int CNT_W  = $clog2(NUM_INPUTS + 1);
  // The exact sum of all weights needs this many bits; the error one more.
  localparam int ACC_W  = WORD_W + 1 + $clog2(NUM_INPUTS);
  localparam int ERR_W  = ACC_W + 1;
  // Rate (made signed) times error.
  localparam int PROD_W = RATE_W + 1 + WORD_W;
  localparam int DLT_W  = PROD_W - RATE_W;
  localparam int UPD_W  = DLT_W + 1;

  localparam logic [CNT_W-1:0] CNT_N = CNT_W'(NUM_INPUTS);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (RATE_W - 1);
  localparam logic signed [ERR_W-1:0] ERR_MAX = {{(ERR_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {{(ERR_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
  localparam logic signed [UPD_W-1:0] UPD_MAX = {{(UPD_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [UPD_W-1:0] UPD_MIN = {{(UPD_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_SAT, S_MUL, S_RND, S_UPD, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RATE_W-1:0] rate;
  logic [TOL_W-1:0]  tol_one;
  logic [TOL_W-1:0]  tol_zero;

  // Item registers.
  logic [CMD_W-1:0]         cmd_q;
  logic                     target_q;
  logic [NUM_INPUTS-1:0]    pix_q;
  logic [CNT_W-1:0]         cnt;
  logic signed [ACC_W-1:0]  acc;
  logic signed [WORD_W-1:0] pot_q;
  logic signed [WORD_W-1:0] err_q;
  logic                     flag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DLT_W-1:0]  delta_q;

  // Weight memory with a valid bit per entry; an entry not yet written reads as zero.
  logic [WORD_W-1:0]     mem [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] vld;
  logic [WORD_W-1:0]     rd_data;
  logic                  rd_vld;
  logic                  rd_lit;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_pend;

  logic                     issue;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [WORD_W-1:0] w_eff;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_wa;
  logic [WORD_W-1:0]        mem_wd;
  logic                     in_acc;
  logic                     widx_ok;
  logic [MAX_INPUTS-1:0]    pix_ext;

  logic signed [ERR_W-1:0]  acc_e;
  logic signed [ERR_W-1:0]  tgt_e;
  logic signed [ERR_W-1:0]  err_full;
  logic signed [WORD_W-1:0] pot_sat;
  logic signed [WORD_W-1:0] err_sat;
  logic [WORD_W:0]          err_mag;
  logic [TOL_W-1:0]         tol_sel;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [UPD_W-1:0]  upd_sum;
  logic signed [WORD_W-1:0] upd_sat;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pix_ext  = {(MAX_INPUTS - PIX_W)'(0), in_data.pixels};
  assign widx_ok  = ((WIDX_W + 1)'(in_data.weight_index) < (WIDX_W + 1)'(NUM_INPUTS));

  // Both sweeps issue one read per cycle until the counter reaches the depth.
  assign issue   = ((state == S_SUM) || (state == S_UPD)) && (cnt < CNT_N);
  assign rd_addr = cnt[IDX_W-1:0];
  assign w_eff   = rd_vld ? $signed(rd_data) : '0;

  // Saturation of the exact sum and error, and the tolerance check.
  always_comb begin
    acc_e    = ERR_W'(acc);
    tgt_e    = target_q ? (ERR_W'(1) << FRAC_BITS) : '0;
    err_full = tgt_e - acc_e;
    if (acc_e > ERR_MAX) begin
      pot_sat = ERR_MAX[WORD_W-1:0];
    end else if (acc_e < ERR_MIN) begin
      pot_sat = ERR_MIN[WORD_W-1:0];
    end else begin
      pot_sat = acc_e[WORD_W-1:0];
    end
    if (err_full > ERR_MAX) begin
      err_sat = ERR_MAX[WORD_W-1:0];
    end else if (err_full < ERR_MIN) begin
      err_sat = ERR_MIN[WORD_W-1:0];
    end else begin
      err_sat = err_full[WORD_W-1:0];
    end
    err_mag = err_sat[WORD_W-1] ? ((WORD_W + 1)'(0) - (WORD_W + 1)'(err_sat))
                                : (WORD_W + 1)'(err_sat);
    tol_sel = target_q ? tol_one : tol_zero;
  end

  // Rounding of the step and the saturating weight update.
  always_comb begin
    prod_rnd = prod_q + ROUND_HALF;
    upd_sum  = UPD_W'(w_eff) + UPD_W'(delta_q);
    if (upd_sum > UPD_MAX) begin
      upd_sat = UPD_MAX[WORD_W-1:0];
    end else if (upd_sum < UPD_MIN) begin
      upd_sat = UPD_MIN[WORD_W-1:0];
    end else begin
      upd_sat = upd_sum[WORD_W-1:0];
    end
  end

  // Write port: a write item from idle, or the write-back of a lit weight.
  // The write-back goes to the entry whose read has just returned, while
  // the read port has moved on to the next entry, so the two never meet.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_idx;
    mem_wd = upd_sat;
    if (in_acc && (in_data.cmd == CMD_WRITE) && widx_ok) begin
      mem_we = 1'b1;
      mem_wa = in_data.weight_index[IDX_W-1:0];
      mem_wd = in_data.weight_value;
    end else if ((state == S_UPD) && rd_pend && rd_lit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
      rd_lit  <= pix_q[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[mem_wa] <= 1'b1;
    end
  end

  // Sequencer (train): sum sweep, saturate, multiply, round, update sweep, deliver.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      cnt       <= '0;
      rate      <= RATE_RESET;
      tol_one   <= TOL1_RESET;
      tol_zero  <= TOL0_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RATE: rate     <= cfg_data[RATE_W-1:0];
          REG_TOL1: tol_one  <= cfg_data[TOL_W-1:0];
          REG_TOL0: tol_zero <= cfg_data[TOL_W-1:0];
          default:  ;
        endcase
      end
      rd_pend <= issue;
      // The delivery stage reloads the output itself when the old result leaves.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= in_data.cmd;
            target_q <= in_data.target;
            pix_q    <= pix_ext[NUM_INPUTS-1:0];
            cnt      <= '0;
            acc      <= '0;
            pot_q    <= '0;
            err_q    <= '0;
            flag_q   <= 1'b0;
            case (in_data.cmd)
              CMD_TRAIN, CMD_EVAL: state <= S_SUM;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_SUM: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (rd_pend && rd_lit) begin
            acc <= acc + ACC_W'(w_eff);
          end
          // The last read returns in the cycle the counter reaches the depth.
          if (cnt == CNT_N) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          pot_q  <= pot_sat;
          err_q  <= err_sat;
          flag_q <= (err_mag > (WORD_W + 1)'(tol_sel));
          state  <= (cmd_q == CMD_TRAIN) ? S_MUL : S_DONE;
        end
        S_MUL: begin
          prod_q <= $signed({1'b0, rate}) * err_q;
          state  <= S_RND;
        end
        S_RND: begin
          delta_q <= prod_rnd[PROD_W-1:RATE_W];
          cnt     <= '0;
          state   <= S_UPD;
        end
        S_UPD: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (cnt == CNT_N) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid                 <= 1'b1;
            out_data.potential        <= pot_q;
            out_data.error            <= err_q;
            out_data.out_of_tolerance <= flag_q;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted item leaves the block busy in the cycle that follows.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input accepted again right after an item");

  // The write-back never targets the entry being read in the same cycle.
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && mem_we && issue) |-> (mem_wa != rd_addr))
    else $error("weight write-back collides with a read");

  // Results appear only from the delivery stage.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside the delivery stage");

  // Saturation follows only a completed sum sweep.
  a_sat_after_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAT) |-> ($past(state == S_SUM) && !rd_pend))
    else $error("sum used before the sweep finished");

  // Memory is written only from idle or during the update sweep.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_UPD))
    else $error("weight memory written in a wrong phase");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Adaline delta-rule neuron, adaline_delta_rule_neuron.
// Depends on adl_pkg for the item types, command codes and register indexes.
module tb;
  import adl_pkg::*;

  // Geometry of the block under test and a few fixed-point landmarks.
  localparam int NUM_PIX = NUM_INPUTS_DEF;
  localparam int FRAC    = FRAC_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
  localparam logic [TOL_W-1:0] EDGE_TOL1 = 31'd4194304;
  localparam logic [TOL_W-1:0] EDGE_TOL0 = 31'd2516582;
  localparam int MAX_IDLE = 18;
  localparam int MAX_REPORTS = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  adl_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  adl_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adaline_delta_rule_neuron u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the neuron: the weight memory and the three registers,
  // starting from their reset values.
  logic signed [WORD_W-1:0] model_w [NUM_PIX] = '{default: '0};
  logic [RATE_W-1:0] model_rate = RATE_RESET;
  logic [TOL_W-1:0]  model_tol1 = TOL1_RESET;
  logic [TOL_W-1:0]  model_tol0 = TOL0_RESET;

  // Results that the neuron owes us, oldest first.
  adl_out_t expected_results [$];

  // Training set used by the random phases: a handful of patterns with their
  // classes, redrawn at the start of every phase.
  logic [PIX_W-1:0] pool_pix [6];
  logic             pool_goal [6];

  int n_errors = 0;
  int n_checked = 0;
  int n_flagged = 0;
  int n_train = 0;
  int n_eval = 0;
  int n_write = 0;
  int n_unused = 0;
  int n_settings = 0;

  // Burst modes switch idling off on either side for a stretch of items.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int unsigned stall_left = 0;

  function automatic logic signed [WORD_W-1:0] clip_word(longint v);
    if (v > WORD_MAX) return W_MAX;
    if (v < WORD_MIN) return W_MIN;
    return v[WORD_W-1:0];
  endfunction

  // Works out the result of one item and applies its effect to the weights.
  // The sum is exact in 64 bits; potential and error are each clipped from it,
  // and the update uses the clipped error with the step rounded half up.
  function automatic adl_out_t neuron_response(adl_in_t item);
    adl_out_t res;
    longint acc, goal, step, mag;
    logic signed [WORD_W-1:0] err_w;
    logic [TOL_W-1:0] tol;
    res = '0;
    if (item.cmd == CMD_TRAIN || item.cmd == CMD_EVAL) begin
      acc = 0;
      for (int i = 0; i < NUM_PIX; i++) begin
        if (item.pixels[i]) acc += longint'(model_w[i]);
      end
      goal = item.target ? (longint'(1) << FRAC) : longint'(0);
      err_w = clip_word(goal - acc);
      res.potential = clip_word(acc);
      res.error = err_w;
      mag = (err_w < 0) ? -longint'(err_w) : longint'(err_w);
      tol = item.target ? model_tol1 : model_tol0;
      res.out_of_tolerance = (mag > longint'(tol));
      if (item.cmd == CMD_TRAIN) begin
        step = (longint'(model_rate) * longint'(err_w) + longint'(1 << (RATE_W - 1)))
               >>> RATE_W;
        for (int i = 0; i < NUM_PIX; i++) begin
          if (item.pixels[i]) model_w[i] = clip_word(longint'(model_w[i]) + step);
        end
      end
    end else if (item.cmd == CMD_WRITE) begin
      if (item.weight_index < NUM_PIX) model_w[item.weight_index] = item.weight_value;
    end
    return res;
  endfunction

  function automatic adl_in_t noise_item();
    adl_in_t it;
    it.cmd = CMD_W'($urandom_range(0, 3));
    it.pixels = {16'($urandom), $urandom};
    it.target = 1'($urandom);
    it.weight_index = WIDX_W'($urandom);
    it.weight_value = $urandom;
    return it;
  endfunction

  function automatic adl_in_t build_item(logic [CMD_W-1:0] cmd, logic [PIX_W-1:0] pixels,
                                         logic target, logic [WIDX_W-1:0] idx,
                                         logic signed [WORD_W-1:0] value);
    adl_in_t it;
    it.cmd = cmd;
    it.pixels = pixels;
    it.target = target;
    it.weight_index = idx;
    it.weight_value = value;
    return it;
  endfunction

  // Patterns of very different densities, from a single pixel to a full retina.
  function automatic logic [PIX_W-1:0] random_pixels();
    logic [PIX_W-1:0] a, b, c;
    a = {16'($urandom), $urandom};
    b = {16'($urandom), $urandom};
    c = {16'($urandom), $urandom};
    case ($urandom_range(0, 5))
      0: return a & b & c;
      1: return a | b;
      2: return PIX_W'(1) << $urandom_range(0, NUM_PIX - 1);
      3: return '1;
      4: return a & b;
      default: return a;
    endcase
  endfunction

  // A starting weight within plus or minus one, as a random start would give.
  function automatic logic signed [WORD_W-1:0] start_weight();
    logic signed [WORD_W-1:0] v;
    v = $urandom;
    return v >>> 7;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    // Keep the log readable if the block goes badly wrong.
    if (n_errors <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offers one item after a random pause and waits until the block takes it.
  // The expected result is worked out at the edge of acceptance, so the copy
  // of the weights follows the block's own order of items.
  task automatic send_item(adl_in_t item);
    int unsigned gap;
    adl_out_t owed;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed = neuron_response(item);
    expected_results.insert(expected_results.size(), owed);
    case (item.cmd)
      CMD_TRAIN: n_train++;
      CMD_EVAL:  n_eval++;
      CMD_WRITE: n_write++;
      default:   n_unused++;
    endcase
  endtask

  // Holds the sender off until every outstanding result has been taken.
  // Each item gives exactly one result, so the block is idle by then; the
  // extra wait after that is margin only.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic apply_settings(logic [RATE_W-1:0] rate, logic [TOL_W-1:0] tol1,
                                logic [TOL_W-1:0] tol0);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_addr <= REG_RATE;
    cfg_data <= CFG_DATA_W'(rate);
    @(posedge clk);
    model_rate = rate;
    cfg_addr <= REG_TOL1;
    cfg_data <= CFG_DATA_W'(tol1);
    @(posedge clk);
    model_tol1 = tol1;
    cfg_addr <= REG_TOL0;
    cfg_data <= CFG_DATA_W'(tol0);
    @(posedge clk);
    model_tol0 = tol0;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic compare_result(adl_out_t got);
    adl_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing outstanding", got.potential, 0);
      return;
    end
    want = expected_results.pop_front();
    n_checked++;
    if (want.out_of_tolerance) n_flagged++;
    if (got.potential !== want.potential)
      report_mismatch("potential", got.potential, want.potential);
    if (got.error !== want.error)
      report_mismatch("error", got.error, want.error);
    if (got.out_of_tolerance !== want.out_of_tolerance)
      report_mismatch("out_of_tolerance", got.out_of_tolerance, want.out_of_tolerance);
  endtask

  // Receiving side: checks every item taken and then holds ready low for a
  // random number of cycles before the next one, except during bursts.
  always @(posedge clk) begin : result_side
    int unsigned hold;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      compare_result(out_data);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold != 0) begin
        out_ready <= 1'b0;
        stall_left = hold;
      end
    end else if (!out_ready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end
  end

  // A phase of learning: a fresh random start for every weight, then mostly
  // training and evaluation on a small set of patterns so that the error
  // settles (or runs away at large rates), mixed with stray patterns,
  // weight writes in and beyond the retina, and pure noise items.
  task automatic random_phase(int unsigned n_items);
    adl_in_t it;
    int unsigned r, pick;
    for (int k = 0; k < 6; k++) begin
      pool_pix[k] = random_pixels();
      pool_goal[k] = 1'($urandom);
    end
    for (int i = 0; i < NUM_PIX; i++)
      send_item(build_item(CMD_WRITE, {16'($urandom), $urandom}, 1'($urandom),
                           WIDX_W'(i), start_weight()));
    repeat (n_items) begin
      it = noise_item();
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, 5);
      if (r < 60) begin
        it.cmd = CMD_TRAIN;
        it.pixels = pool_pix[pick];
        it.target = pool_goal[pick];
      end else if (r < 78) begin
        it.cmd = CMD_EVAL;
        it.pixels = pool_pix[pick];
      end else if (r < 86) begin
        it.cmd = CMD_EVAL;
        it.pixels = random_pixels();
      end else if (r < 93) begin
        it.cmd = CMD_WRITE;
        if ($urandom_range(0, 3) != 0) it.weight_value = start_weight();
      end else if (r < 97) begin
        it.cmd = CMD_TRAIN;
        it.pixels = random_pixels();
      end
      // Anything else goes out as drawn, the unused command code included.
      send_item(it);
    end
  endtask

  // Straight after reset every weight reads as zero.
  task automatic test_reset_state();
    send_item(build_item(CMD_EVAL, '1, 1'b0, '0, '0));
    send_item(build_item(CMD_EVAL, '0, 1'b1, '0, '0));
    send_item(build_item(CMD_UNUSED, '1, 1'b1, '1, W_MAX));
  endtask

  // Extreme weights drive the sum past the word range in both directions;
  // writes beyond the retina must leave the weights alone.
  task automatic test_saturation();
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd0, W_MAX));
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd1, W_MAX));
    send_item(build_item(CMD_WRITE, '1, 1'b1, 6'd2, W_MIN));
    send_item(build_item(CMD_WRITE, '1, 1'b1, 6'd3, W_MIN));
    send_item(build_item(CMD_EVAL, 48'h3, 1'b0, '0, '0));
    send_item(build_item(CMD_EVAL, 48'hC, 1'b1, '0, '0));
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd48, W_MAX));
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd63, W_MIN));
    send_item(build_item(CMD_EVAL, '1, 1'b0, '1, '1));
  endtask

  // Training steps that push one weight past the top and another past the
  // bottom of the word range, the latter from a saturated error.
  task automatic test_update_clipping();
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd4, 32'sh7FFF_FFF0));
    send_item(build_item(CMD_TRAIN, 48'h14, 1'b1, '0, '0));
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd5, 32'sh8000_0010));
    send_item(build_item(CMD_TRAIN, 48'h23, 1'b0, '0, '0));
    send_item(build_item(CMD_EVAL, 48'h37, 1'b1, '0, '0));
  endtask

  // An error exactly at the tolerance is inside it; one more step is not.
  task automatic test_tolerance_edges();
    apply_settings(RATE_RESET, EDGE_TOL1, EDGE_TOL0);
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd6, WORD_W'(-longint'(EDGE_TOL0))));
    send_item(build_item(CMD_EVAL, 48'h40, 1'b0, '0, '0));
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd6, WORD_W'(-longint'(EDGE_TOL0) - 1)));
    send_item(build_item(CMD_EVAL, 48'h40, 1'b0, '0, '0));
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd6,
                         WORD_W'((longint'(1) << FRAC) - longint'(EDGE_TOL1))));
    send_item(build_item(CMD_EVAL, 48'h40, 1'b1, '0, '0));
    send_item(build_item(CMD_WRITE, '0, 1'b0, 6'd6,
                         WORD_W'((longint'(1) << FRAC) - longint'(EDGE_TOL1) - 1)));
    send_item(build_item(CMD_EVAL, 48'h40, 1'b1, '0, '0));
  endtask

  task automatic test_learning_default_rate();
    apply_settings(RATE_RESET, TOL1_RESET, TOL0_RESET);
    random_phase(220);
  endtask

  // A rate of almost one with dense patterns makes the weights run away.
  task automatic test_full_rate_zero_tolerance();
    apply_settings('1, '0, '0);
    random_phase(170);
  endtask

  task automatic test_frozen_weights();
    apply_settings('0, '1, '1);
    random_phase(170);
  endtask

  task automatic test_moderate_rates();
    apply_settings(RATE_W'($urandom_range(1000, 20000)), TOL_W'($urandom_range(0, 1 << FRAC)),
                   TOL_W'($urandom_range(0, 1 << FRAC)));
    random_phase(200);
  endtask

  task automatic test_random_settings();
    apply_settings(RATE_W'($urandom), TOL_W'($urandom), TOL_W'($urandom));
    random_phase(200);
  endtask

  task automatic test_smallest_rate();
    apply_settings(RATE_W'(1), TOL_W'($urandom_range(0, 1 << 20)),
                   TOL_W'($urandom_range(0, 1 << 20)));
    random_phase(170);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_saturation();
    test_update_clipping();
    test_tolerance_edges();
    test_learning_default_rate();
    test_full_rate_zero_tolerance();
    test_frozen_weights();
    test_moderate_rates();
    test_random_settings();
    test_smallest_rate();
    wait_for_results();
    // A train item is the longest kind, so anything stray shows up well within
    // this window.
    repeat (150) @(posedge clk);
    $display("Checked %0d results: %0d train, %0d evaluate, %0d write, %0d unused; %0d flagged.",
             n_checked, n_train, n_eval, n_write, n_unused, n_flagged);
    $display("Went through %0d register settings, from a frozen zero rate to full scale.",
             n_settings);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of these items.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/adl_pkg.sv
rtl/core/adaline_delta_rule_neuron.sv
test/tb.sv
